// ===== src/mpq_pkg.sv =====
package mpq_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int KEY_W    = 32;
  localparam int ID_W     = 16;
  localparam int TAG_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic [ID_W-1:0]  id;
  } entry_t;

  typedef struct packed {
    logic do_insert;
    logic do_extract;
  } cell_ctrl_t;

endpackage

// ===== src/mpq_cell.sv =====
module mpq_cell (
  input  logic               clk,
  input  mpq_pkg::cell_ctrl_t ctrl,
  input  logic               occupied,
  input  mpq_pkg::entry_t    new_entry,
  input  mpq_pkg::entry_t    left_entry,
  input  mpq_pkg::entry_t    right_entry,
  input  logic               prev_ahead,
  output logic               new_ahead,
  output mpq_pkg::entry_t    entry
);

  mpq_pkg::entry_t entry_r;
  mpq_pkg::entry_t entry_nxt;
  logic            new_first;

  // smaller key first; equal keys fall back to the order tag
  assign new_first = (new_entry.key < entry_r.key) ||
                     ((new_entry.key == entry_r.key) && (new_entry.tag < entry_r.tag));

  // an empty cell stands for an infinite key
  assign new_ahead = occupied ? new_first : 1'b1;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.do_insert) begin
      if (prev_ahead) begin
        entry_nxt = left_entry;
      end else if (new_ahead) begin
        entry_nxt = new_entry;
      end
    end else if (ctrl.do_extract) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// ===== src/min_priority_queue_top.sv =====
// Channel  | Direction | Handshake             | Payload
// command  | in        | start high, busy low  | in_command, in_item_id, in_item_key
// result   | out       | out_valid, one cycle  | out_status, out_id, out_key, out_count
//
// An accepted command is applied to the cell chain on the next cycle and its result is
// on the ports, with out_valid high for one cycle, after that; busy is high only during
// the apply cycle, so no new command is taken until the chain update that follows the capture.
// Synchronous active-low reset empties the queue and clears the insert sequence.
// The receiver cannot stall: every result is taken in the cycle it is shown.
module min_priority_queue_top #(
  parameter int CAPACITY = mpq_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_command,
  input  logic [mpq_pkg::ID_W-1:0]      in_item_id,
  input  logic [mpq_pkg::KEY_W-1:0]     in_item_key,
  output logic                          out_valid,
  output logic [mpq_pkg::STATUS_W-1:0]  out_status,
  output logic [mpq_pkg::ID_W-1:0]      out_id,
  output logic [mpq_pkg::KEY_W-1:0]     out_key,
  output logic [mpq_pkg::COUNT_W-1:0]   out_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                          pend_r;
  logic                          cmd_r;
  logic [mpq_pkg::ID_W-1:0]      id_r;
  logic [mpq_pkg::KEY_W-1:0]     key_r;
  logic [mpq_pkg::TAG_W-1:0]     seq_r;
  logic [mpq_pkg::TAG_W-1:0]     seq_nxt;
  logic [CNT_W-1:0]              held_cnt_r;
  logic [CNT_W-1:0]              held_cnt_nxt;
  logic                          out_valid_r;
  logic [mpq_pkg::STATUS_W-1:0]  out_status_r;
  logic [mpq_pkg::STATUS_W-1:0]  out_status_nxt;
  logic [mpq_pkg::ID_W-1:0]      out_id_r;
  logic [mpq_pkg::ID_W-1:0]      out_id_nxt;
  logic [mpq_pkg::KEY_W-1:0]     out_key_r;
  logic [mpq_pkg::KEY_W-1:0]     out_key_nxt;
  logic [mpq_pkg::COUNT_W-1:0]   out_count_r;

  logic                          accept;
  logic                          full;
  logic                          empty;
  mpq_pkg::cell_ctrl_t           ctrl;
  mpq_pkg::entry_t               new_entry;
  mpq_pkg::entry_t               cell_entry [CAPACITY];
  logic [CAPACITY-1:0]           cell_ahead;

  assign accept = start && !pend_r;
  assign busy   = pend_r;
  assign full   = (held_cnt_r == CNT_W'(CAPACITY));
  assign empty  = (held_cnt_r == '0);

  assign ctrl.do_insert  = pend_r && (cmd_r == mpq_pkg::CMD_INSERT) && !full;
  assign ctrl.do_extract = pend_r && (cmd_r == mpq_pkg::CMD_EXTRACT) && !empty;

  assign new_entry.key = key_r;
  assign new_entry.tag = seq_r;
  assign new_entry.id  = id_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    mpq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (held_cnt_r > CNT_W'(i)),
      .new_entry   (new_entry),
      .left_entry  ((i == 0) ? new_entry : cell_entry[(i == 0) ? 0 : i - 1]),
      .right_entry ((i == CAPACITY - 1) ? cell_entry[i]
                                        : cell_entry[(i == CAPACITY - 1) ? i : i + 1]),
      .prev_ahead  ((i == 0) ? 1'b0 : cell_ahead[(i == 0) ? 0 : i - 1]),
      .new_ahead   (cell_ahead[i]),
      .entry       (cell_entry[i])
    );
  end

  always_comb begin
    held_cnt_nxt   = held_cnt_r;
    seq_nxt        = seq_r;
    out_status_nxt = mpq_pkg::ST_DONE;
    out_id_nxt     = '0;
    out_key_nxt    = '0;
    if (cmd_r == mpq_pkg::CMD_INSERT) begin
      if (full) begin
        out_status_nxt = mpq_pkg::ST_FULL;
      end else begin
        held_cnt_nxt = held_cnt_r + CNT_W'(1);
        seq_nxt      = seq_r + mpq_pkg::TAG_W'(1);
      end
    end else begin
      if (empty) begin
        out_status_nxt = mpq_pkg::ST_EMPTY;
      end else begin
        held_cnt_nxt = held_cnt_r - CNT_W'(1);
        out_id_nxt   = cell_entry[0].id;
        out_key_nxt  = cell_entry[0].key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      held_cnt_r  <= '0;
      seq_r       <= '0;
    end else begin
      out_valid_r <= pend_r;
      if (accept) begin
        pend_r <= 1'b1;
      end else if (pend_r) begin
        pend_r     <= 1'b0;
        held_cnt_r <= held_cnt_nxt;
        seq_r      <= seq_nxt;
      end
    end
  end

  // hold the command payload for the apply cycle and register the result
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command;
      id_r  <= in_item_id;
      key_r <= in_item_key;
    end
    if (pend_r) begin
      out_status_r <= out_status_nxt;
      out_id_r     <= out_id_nxt;
      out_key_r    <= out_key_nxt;
      out_count_r  <= mpq_pkg::COUNT_W'(held_cnt_nxt);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_id     = out_id_r;
  assign out_key    = out_key_r;
  assign out_count  = out_count_r;

endmodule
